>>> sv/pcache_pkg.sv
// ----------------------------------------------------------------------------
// pcache_pkg
// Types and fixed widths shared by the peer cache modules.
// ----------------------------------------------------------------------------
package pcache_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned EXPIRY_W  = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [15:0] EXPIRY_RESET = 16'd30;

  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [63:0]       user_id_w0;
    logic [63:0]       user_id_w1;
    logic [63:0]       user_id_w2;
    logic [63:0]       user_id_w3;
    logic [63:0]       host_id_w0;
    logic [63:0]       host_id_w1;
    logic [63:0]       host_id_w2;
    logic [63:0]       host_id_w3;
    logic [31:0]       now_seconds;
    logic [31:0]       peer_ip;
    logic [15:0]       peer_port;
  } in_t;

  typedef struct packed {
    logic       hit;
    logic       inserted;
    logic       table_full;
    logic [3:0] slot;
  } out_t;

  typedef struct packed {
    logic expired;
    logic live;
    logic match;
  } eval_t;

endpackage

>>> sv/peer_cache_with_aging_top.sv
// ----------------------------------------------------------------------------
// peer_cache_with_aging_top
// Peer table with timeout aging: lookup, refresh, insert and clear.
// ----------------------------------------------------------------------------
//  channel  signals                      word
//  in       in_valid, in_ready, in_data  pcache_pkg::in_t
//  out      out_valid, out_ready, out_data pcache_pkg::out_t
//  cfg      cfg_write, cfg_data          expiry limit, 16 bits
//
//  A report scans one entry per cycle from the entry RAM and stops early on a
//  hit; a clear does not scan. One word at a time.
//  Reset clears all valid bits and loads the expiry limit with 30.
//  A finished result waits in an internal register while out_valid is high and
//  out_ready low; in_ready stays low until it moves to the output register.
// ----------------------------------------------------------------------------
module peer_cache_with_aging_top #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned ID_WORDS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcache_pkg::in_t      in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcache_pkg::out_t     out_data,
  input  logic                 cfg_write,
  input  logic [15:0]          cfg_data
);

  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned ID_W      = pcache_pkg::WORD_W * ID_WORDS;
  localparam int unsigned STAMP_LSB = 0;
  localparam int unsigned PORT_LSB  = STAMP_LSB + pcache_pkg::STAMP_W;
  localparam int unsigned ADDR_LSB  = PORT_LSB + pcache_pkg::PORT_W;
  localparam int unsigned UID_LSB   = ADDR_LSB + pcache_pkg::ADDR_W;
  localparam int unsigned HID_LSB   = UID_LSB + ID_W;
  localparam int unsigned ENT_W     = HID_LSB + ID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                          state;
  logic [IDX_W-1:0]                    idx;
  logic [IDX_W-1:0]                    free_slot;
  logic                                free_ok;
  logic [ENTRIES-1:0]                  vld;
  logic [pcache_pkg::EXPIRY_W-1:0]     expiry;
  pcache_pkg::in_t                     req;
  pcache_pkg::out_t                    res;

  logic                                we;
  logic [IDX_W-1:0]                    waddr;
  logic [ENT_W-1:0]                    wdata;
  logic [IDX_W-1:0]                    raddr;
  logic [ENT_W-1:0]                    rdata;
  logic [ENT_W-1:0]                    new_word;
  logic [ID_W-1:0]                     req_uid;
  logic [ID_W-1:0]                     req_hid;
  logic                                last;
  logic                                take_free;
  logic [IDX_W-1:0]                    slot_sel;
  pcache_pkg::eval_t                   ev;

  always_comb begin
    req_uid = ID_W'({req.user_id_w3, req.user_id_w2, req.user_id_w1, req.user_id_w0});
    req_hid = ID_W'({req.host_id_w3, req.host_id_w2, req.host_id_w1, req.host_id_w0});
    new_word = {req_hid, req_uid, req.peer_ip, req.peer_port, req.now_seconds};
  end

  pcache_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pcache_eval #(
    .ID_WORDS (ID_WORDS)
  ) u_eval (
    .vld     (vld[idx]),
    .stamp   (rdata[STAMP_LSB +: pcache_pkg::STAMP_W]),
    .now     (req.now_seconds),
    .expiry  (expiry),
    .ent_uid (rdata[UID_LSB +: ID_W]),
    .ent_hid (rdata[HID_LSB +: ID_W]),
    .req_uid (req_uid),
    .req_hid (req_hid),
    .ev      (ev)
  );

  always_comb begin
    in_ready  = (state == ST_IDLE);
    raddr     = (state == ST_SCAN) ? idx + IDX_W'(1) : '0;
    last      = (idx == IDX_W'(ENTRIES - 1));
    take_free = free_ok || !ev.live;
    slot_sel  = !ev.live ? idx : free_slot;
    we        = 1'b0;
    waddr     = idx;
    wdata     = new_word;
    if (state == ST_SCAN) begin
      if (ev.live && ev.match) begin
        we    = 1'b1;
        wdata = rdata;
        wdata[STAMP_LSB +: pcache_pkg::STAMP_W] = req.now_seconds;
      end else if (last && take_free) begin
        we    = 1'b1;
        waddr = slot_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      expiry    <= pcache_pkg::EXPIRY_RESET;
      out_valid <= 1'b0;
      free_ok   <= 1'b0;
    end else begin
      if (cfg_write) begin
        expiry <= cfg_data;
      end
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req     <= in_data;
            idx     <= '0;
            free_ok <= 1'b0;
            if (in_data.mode == pcache_pkg::MODE_CLEAR) begin
              vld   <= '0;
              res   <= '0;
              state <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (ev.expired && !last) begin
            vld[idx] <= 1'b0;
          end
          if (ev.live && ev.match) begin
            res.hit        <= 1'b1;
            res.inserted   <= 1'b0;
            res.table_full <= 1'b0;
            res.slot       <= pcache_pkg::SLOT_W'(idx);
            state          <= ST_FIN;
          end else begin
            if (!ev.live) begin
              free_ok   <= 1'b1;
              free_slot <= idx;
            end
            if (last) begin
              res.hit <= 1'b0;
              if (take_free) begin
                vld[slot_sel]  <= 1'b1;
                res.inserted   <= 1'b1;
                res.table_full <= 1'b0;
                res.slot       <= pcache_pkg::SLOT_W'(slot_sel);
              end else begin
                res.inserted   <= 1'b0;
                res.table_full <= 1'b1;
                res.slot       <= '0;
              end
              state <= ST_FIN;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/pcache_ram.sv
// ----------------------------------------------------------------------------
// pcache_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pcache_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pcache_eval.sv
// ----------------------------------------------------------------------------
// pcache_eval
// Age check and id compare of one table entry against the current report.
// ----------------------------------------------------------------------------
module pcache_eval #(
  parameter int unsigned ID_WORDS = 4
) (
  input  logic                                 vld,
  input  logic [pcache_pkg::STAMP_W-1:0]       stamp,
  input  logic [pcache_pkg::STAMP_W-1:0]       now,
  input  logic [pcache_pkg::EXPIRY_W-1:0]      expiry,
  input  logic [pcache_pkg::WORD_W*ID_WORDS-1:0] ent_uid,
  input  logic [pcache_pkg::WORD_W*ID_WORDS-1:0] ent_hid,
  input  logic [pcache_pkg::WORD_W*ID_WORDS-1:0] req_uid,
  input  logic [pcache_pkg::WORD_W*ID_WORDS-1:0] req_hid,
  output pcache_pkg::eval_t                    ev
);

  logic [pcache_pkg::STAMP_W-1:0] age;

  always_comb begin
    age        = now - stamp;
    ev.expired = vld && (age > pcache_pkg::STAMP_W'(expiry));
    ev.live    = vld && !ev.expired;
    ev.match   = (ent_uid == req_uid) && (ent_hid == req_hid);
  end

endmodule
